FILE: src/icwrm_pkg.sv
// ----------------------------------------------------------------------------
// icwrm_pkg
// Shared types and constants for the image crop block with reuse marks.
// ----------------------------------------------------------------------------
package icwrm_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Widest linear index the parameter range can need (4096 x 4096)
    localparam int CMD_IDX_W = 24;
    // Dimensions and scan arithmetic
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam logic [7:0] ALPHA_LIMIT = 8'd240;
    localparam int         ALPHA_LSB   = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REUSE_CHECK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BOTTOM = 3'd6;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_EMPTY   = 2'd1,
        CMD_OUTSIDE = 2'd2,
        CMD_INSIDE  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] load_index;
        logic [31:0] load_pixel;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
        logic        empty_window;
        logic        outside_image;
        logic        was_reused;
    } out_item_t;

    // Classified work handed from the front to the back
    typedef struct packed {
        cmd_kind_t            kind;
        logic [CMD_IDX_W-1:0] idx;
        logic [31:0]          pixel;
        logic                 last;
        logic                 reuse;
    } cmd_t;

endpackage

FILE: src/icwrm_front.sv
// ----------------------------------------------------------------------------
// icwrm_front
// Holds configuration and scan position, accepts items and classifies them.
// ----------------------------------------------------------------------------
module icwrm_front #(
    parameter int MAX_WIDTH  = icwrm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = icwrm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  icwrm_pkg::in_item_t                  in_data,
    input  logic                                 cfg_write,
    input  logic [icwrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [icwrm_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic                                 clearing,
    input  logic                                 q_full,
    output logic                                 q_push,
    output icwrm_pkg::cmd_t                      q_cmd
);
    import icwrm_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [8:0]                image_width_reg;
    logic [8:0]                image_height_reg;
    logic                      reuse_reg;
    logic signed [COORD_W-1:0] win_left_reg;
    logic signed [COORD_W-1:0] win_top_reg;
    logic signed [COORD_W-1:0] win_right_reg;
    logic signed [COORD_W-1:0] win_bottom_reg;

    logic signed [COORD_W-1:0] scan_col_reg, scan_col_next;
    logic signed [COORD_W-1:0] scan_row_reg, scan_row_next;
    logic                      scan_valid_reg, scan_valid_next;

    logic                      accept;
    logic                      is_emit;
    logic                      load_in_range;
    logic [DIM_W-1:0]          eff_w, eff_h;
    logic                      win_empty;
    logic signed [COORD_W-1:0] col, row;
    logic signed [DIM_W-1:0]   col_inc, row_inc;
    logic                      col_end, row_end;
    logic                      in_image;
    logic [2*DIM_W-1:0]        lin_idx;

    assign in_stall = clearing || q_full;
    assign accept   = in_valid && !in_stall;
    assign is_emit  = in_data.operation;
    assign load_in_range = 32'(in_data.load_index) < 32'(DEPTH);

    assign eff_w = (DIM_W'(image_width_reg) > DIM_W'(MAX_WIDTH))
                   ? DIM_W'(MAX_WIDTH) : DIM_W'(image_width_reg);
    assign eff_h = (DIM_W'(image_height_reg) > DIM_W'(MAX_HEIGHT))
                   ? DIM_W'(MAX_HEIGHT) : DIM_W'(image_height_reg);

    assign win_empty = (eff_w == '0) || (eff_h == '0) ||
                       !(win_left_reg < win_right_reg) ||
                       !(win_top_reg < win_bottom_reg);

    assign col = scan_valid_reg ? scan_col_reg : win_left_reg;
    assign row = scan_valid_reg ? scan_row_reg : win_top_reg;

    assign in_image = !col[COORD_W-1] && ({1'b0, col} < eff_w) &&
                      !row[COORD_W-1] && ({1'b0, row} < eff_h);

    // One extra bit so the last column or row plus one cannot wrap
    assign col_inc = {col[COORD_W-1], col} + DIM_W'(1);
    assign row_inc = {row[COORD_W-1], row} + DIM_W'(1);
    assign col_end = col_inc >= $signed({win_right_reg[COORD_W-1], win_right_reg});
    assign row_end = row_inc >= $signed({win_bottom_reg[COORD_W-1], win_bottom_reg});

    assign lin_idx = ({1'b0, row} * eff_w) + (2*DIM_W)'({1'b0, col});

    always_comb
    begin
        q_push      = 1'b0;
        q_cmd.kind  = CMD_LOAD;
        q_cmd.idx   = CMD_IDX_W'(in_data.load_index);
        q_cmd.pixel = in_data.load_pixel;
        q_cmd.last  = 1'b0;
        q_cmd.reuse = reuse_reg;

        scan_col_next   = scan_col_reg;
        scan_row_next   = scan_row_reg;
        scan_valid_next = scan_valid_reg;

        if (accept)
        begin
            if (!is_emit)
            begin
                q_push = load_in_range;
            end
            else
            begin
                q_push      = 1'b1;
                q_cmd.pixel = '0;
                q_cmd.idx   = CMD_IDX_W'(lin_idx);
                if (win_empty)
                begin
                    q_cmd.kind      = CMD_EMPTY;
                    q_cmd.last      = 1'b1;
                    scan_valid_next = 1'b0;
                end
                else
                begin
                    q_cmd.kind = in_image ? CMD_INSIDE : CMD_OUTSIDE;
                    q_cmd.last = col_end && row_end;
                    if (col_end)
                    begin
                        if (row_end)
                        begin
                            scan_valid_next = 1'b0;
                        end
                        else
                        begin
                            scan_col_next   = win_left_reg;
                            scan_row_next   = row_inc[COORD_W-1:0];
                            scan_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        scan_col_next   = col_inc[COORD_W-1:0];
                        scan_row_next   = row;
                        scan_valid_next = 1'b1;
                    end
                end
            end
        end

        // Any write to a defined register restarts the scan
        if (cfg_write && (cfg_index <= REG_WINDOW_BOTTOM))
        begin
            scan_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 9'd256;
            image_height_reg <= 9'd256;
            reuse_reg        <= 1'b0;
            win_left_reg     <= '0;
            win_top_reg      <= '0;
            win_right_reg    <= '0;
            win_bottom_reg   <= '0;
            scan_col_reg     <= '0;
            scan_row_reg     <= '0;
            scan_valid_reg   <= 1'b0;
        end
        else
        begin
            scan_col_reg   <= scan_col_next;
            scan_row_reg   <= scan_row_next;
            scan_valid_reg <= scan_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   image_width_reg  <= cfg_data[8:0];
                    REG_IMAGE_HEIGHT:  image_height_reg <= cfg_data[8:0];
                    REG_REUSE_CHECK:   reuse_reg        <= cfg_data[0];
                    REG_WINDOW_LEFT:   win_left_reg     <= cfg_data;
                    REG_WINDOW_TOP:    win_top_reg      <= cfg_data;
                    REG_WINDOW_RIGHT:  win_right_reg    <= cfg_data;
                    REG_WINDOW_BOTTOM: win_bottom_reg   <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

endmodule

FILE: src/icwrm_queue.sv
// ----------------------------------------------------------------------------
// icwrm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module icwrm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  icwrm_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output icwrm_pkg::cmd_t head,
    output logic            avail
);
    import icwrm_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign avail   = count_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/icwrm_back.sv
// ----------------------------------------------------------------------------
// icwrm_back
// Pixel store, used-mark store and result register; carries out commands.
// ----------------------------------------------------------------------------
module icwrm_back #(
    parameter int MAX_WIDTH  = icwrm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = icwrm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_avail,
    input  icwrm_pkg::cmd_t      q_head,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 out_valid,
    input  logic                 out_stall,
    output icwrm_pkg::out_item_t out_data
);
    import icwrm_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_READ  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    cmd_t             cur_reg, cur_next;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic [31:0] store_mem [DEPTH];
    logic        mark_mem  [DEPTH];
    logic [31:0] store_rdata_reg;
    logic        mark_rdata_reg;

    logic             out_free;
    logic             produce;
    out_item_t        res;
    logic [IDX_W-1:0] head_addr;
    logic             st_we;
    logic             rd_en;
    logic             mk_we;
    logic [IDX_W-1:0] mk_addr;
    logic             mk_wdata;

    assign clearing  = state_reg == ST_CLEAR;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign head_addr = IDX_W'(q_head.idx);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        q_pop        = 1'b0;
        produce      = 1'b0;
        res          = '0;
        st_we        = 1'b0;
        rd_en        = 1'b0;
        mk_we        = 1'b0;
        mk_addr      = clr_cnt_reg;
        mk_wdata     = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mk_we        = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (q_avail)
                begin
                    case (q_head.kind)
                        CMD_LOAD:
                        begin
                            q_pop = 1'b1;
                            st_we = 1'b1;
                        end
                        CMD_INSIDE:
                        begin
                            q_pop      = 1'b1;
                            rd_en      = 1'b1;
                            cur_next   = q_head;
                            state_next = ST_READ;
                        end
                        CMD_OUTSIDE:
                        begin
                            if (out_free)
                            begin
                                q_pop             = 1'b1;
                                produce           = 1'b1;
                                res.outside_image = 1'b1;
                                res.last          = q_head.last;
                            end
                        end
                        CMD_EMPTY:
                        begin
                            if (out_free)
                            begin
                                q_pop            = 1'b1;
                                produce          = 1'b1;
                                res.empty_window = 1'b1;
                                res.last         = 1'b1;
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    produce    = 1'b1;
                    res.last   = cur_reg.last;
                    res.pixel  = store_rdata_reg;
                    state_next = ST_RUN;
                    if (cur_reg.reuse)
                    begin
                        if (mark_rdata_reg)
                        begin
                            res.was_reused = 1'b1;
                            // weak alpha on reuse is suppressed
                            if (!(store_rdata_reg[ALPHA_LSB +: 8] > ALPHA_LIMIT))
                            begin
                                res.pixel = '0;
                            end
                        end
                        else
                        begin
                            mk_we    = 1'b1;
                            mk_addr  = IDX_W'(cur_reg.idx);
                            mk_wdata = 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (produce)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[head_addr] <= q_head.pixel;
        end
        if (rd_en)
        begin
            store_rdata_reg <= store_mem[head_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mk_we)
        begin
            mark_mem[mk_addr] <= mk_wdata;
        end
        if (rd_en)
        begin
            mark_rdata_reg <= mark_mem[head_addr];
        end
    end

endmodule

FILE: src/image_crop_with_reuse_marks_core.sv
// ----------------------------------------------------------------------------
// image_crop_with_reuse_marks_core
// Crops a stored RGBA image to a window, optionally flagging reused pixels.
//
// After reset the block clears all MAX_WIDTH * MAX_HEIGHT used-pixel marks
// (65536 at the default size), one entry per cycle, and holds in_stall high
// meanwhile; configuration writes are taken at any time. The front takes
// one item per cycle, while the queue is not full, into a two-entry command
// queue. The back retires a load, an empty-window result or an outside-image
// result straight from the queue head, and an in-image result in two steps:
// a registered read of the pixel and mark stores, then forming the result
// and writing the mark back. Results leave through an output register, so a
// stalled output does not stop new items entering until the queue is full.
// ----------------------------------------------------------------------------
module image_crop_with_reuse_marks_core #(
    parameter int MAX_WIDTH  = icwrm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = icwrm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  icwrm_pkg::in_item_t             in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output icwrm_pkg::out_item_t            out_data,
    input  logic                            cfg_write,
    input  logic [icwrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [icwrm_pkg::CFG_DAT_W-1:0] cfg_data
);
    import icwrm_pkg::*;

    logic clearing;
    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic q_avail;
    cmd_t q_head;

    icwrm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    icwrm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .avail    (q_avail)
    );

    icwrm_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_avail   (q_avail),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
